// File: src/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Differential drive odometry package
// Shared constants, command and status types and the arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CNT_W = 5;

    // Angles in Q3.29 radians, gain and unit in Q1.30.
    localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
    localparam logic [31:0] PI_Q29      = 32'd1686629713;
    localparam logic [31:0] HALF_PI_Q29 = 32'd843314857;
    localparam logic [31:0] GAIN_Q30    = 32'd652032874;
    localparam logic [31:0] ONE_Q30     = 32'd1073741824;

    // Reduction starts at 2pi shifted by this amount.
    localparam logic [CNT_W-1:0] WRAP_TOP = 5'd31;
    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);

    // Operation codes.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_SET_X  = 2'd1;
    localparam logic [1:0] OP_SET_Y  = 2'd2;
    localparam logic [1:0] OP_SET_HD = 2'd3;

    // Register index in address bit 2.
    localparam logic REG_INV_WHEEL_BASE = 1'b0;
    localparam logic [31:0] INV_WHEEL_BASE_RST = 32'd1048576;

    // Wrap input select.
    localparam logic [1:0] WSEL_SUM     = 2'd0;
    localparam logic [1:0] WSEL_VAL     = 2'd1;
    localparam logic [1:0] WSEL_VALTERM = 2'd2;

    // Wrap result destination.
    localparam logic [1:0] WDST_SAMPLE = 2'd0;
    localparam logic [1:0] WDST_HEAD   = 2'd1;
    localparam logic [1:0] WDST_OFFSET = 2'd2;

    typedef struct packed {
        logic             latch;
        logic             term;
        logic             wload;
        logic [1:0]       wsel;
        logic             witer;
        logic             wfin;
        logic [1:0]       wdest;
        logic             cload;
        logic             citer;
        logic             cfin;
        logic             mul;
        logic             add;
        logic             setpos;
        logic             axis;
        logic             out_load;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_op;
        logic       out_free;
    } t_sts;

    function automatic logic [31:0] atan_q29(input logic [CNT_W-1:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd421657428;
            5'd1:  v = 32'd248918915;
            5'd2:  v = 32'd131521918;
            5'd3:  v = 32'd66762579;
            5'd4:  v = 32'd33510843;
            5'd5:  v = 32'd16771758;
            5'd6:  v = 32'd8387925;
            5'd7:  v = 32'd4194219;
            5'd8:  v = 32'd2097141;
            5'd9:  v = 32'd1048575;
            5'd10: v = 32'd524288;
            5'd11: v = 32'd262144;
            5'd12: v = 32'd131072;
            5'd13: v = 32'd65536;
            5'd14: v = 32'd32768;
            5'd15: v = 32'd16384;
            5'd16: v = 32'd8192;
            5'd17: v = 32'd4096;
            5'd18: v = 32'd2048;
            5'd19: v = 32'd1024;
            5'd20: v = 32'd512;
            5'd21: v = 32'd256;
            5'd22: v = 32'd128;
            5'd23: v = 32'd64;
            5'd24: v = 32'd32;
            5'd25: v = 32'd16;
            5'd26: v = 32'd8;
            5'd27: v = 32'd4;
            5'd28: v = 32'd2;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: src/ddo_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry controller
// Sequences term, angle wrap, CORDIC and position update for a sample, and the steps of a set.
// ----------------------------------------------------------------------------
module ddo_ctrl
    import ddo_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_in_ready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TERM  = 4'd1;
    localparam logic [3:0] S_WLOAD = 4'd2;
    localparam logic [3:0] S_WITER = 4'd3;
    localparam logic [3:0] S_WFIN  = 4'd4;
    localparam logic [3:0] S_CLOAD = 4'd5;
    localparam logic [3:0] S_CITER = 4'd6;
    localparam logic [3:0] S_CFIN  = 4'd7;
    localparam logic [3:0] S_MULX  = 4'd8;
    localparam logic [3:0] S_ADDX  = 4'd9;
    localparam logic [3:0] S_MULY  = 4'd10;
    localparam logic [3:0] S_ADDY  = 4'd11;
    localparam logic [3:0] S_SETP  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_op, n_op;
    logic             r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_op    <= OP_SAMPLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_op    <= n_op;
            r_phase <= n_phase;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_phase = r_phase;
        o_cmd   = '0;
        o_cmd.idx = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_op = i_sts.in_op;
                    n_phase = 1'b0;
                    if (i_sts.in_op == OP_SAMPLE || i_sts.in_op == OP_SET_HD) begin
                        n_state = S_TERM;
                    end else begin
                        n_state = S_SETP;
                    end
                end
            end
            S_TERM: begin
                o_cmd.term = 1'b1;
                n_state = S_WLOAD;
            end
            S_WLOAD: begin
                o_cmd.wload = 1'b1;
                if (r_op == OP_SAMPLE) begin
                    o_cmd.wsel = WSEL_SUM;
                end else if (r_phase) begin
                    o_cmd.wsel = WSEL_VALTERM;
                end else begin
                    o_cmd.wsel = WSEL_VAL;
                end
                n_cnt = WRAP_TOP;
                n_state = S_WITER;
            end
            S_WITER: begin
                o_cmd.witer = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_WFIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_WFIN: begin
                o_cmd.wfin = 1'b1;
                if (r_op == OP_SAMPLE) begin
                    o_cmd.wdest = WDST_SAMPLE;
                    n_state = S_CLOAD;
                end else if (r_phase) begin
                    o_cmd.wdest = WDST_OFFSET;
                    n_state = S_DONE;
                end else begin
                    o_cmd.wdest = WDST_HEAD;
                    n_phase = 1'b1;
                    n_state = S_WLOAD;
                end
            end
            S_CLOAD: begin
                o_cmd.cload = 1'b1;
                n_cnt = '0;
                n_state = S_CITER;
            end
            S_CITER: begin
                o_cmd.citer = 1'b1;
                if (r_cnt == CORDIC_LAST) begin
                    n_state = S_CFIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CFIN: begin
                o_cmd.cfin = 1'b1;
                n_state = S_MULX;
            end
            S_MULX: begin
                o_cmd.mul = 1'b1;
                n_state = S_ADDX;
            end
            S_ADDX: begin
                o_cmd.add = 1'b1;
                n_state = S_MULY;
            end
            S_MULY: begin
                o_cmd.mul = 1'b1;
                o_cmd.axis = 1'b1;
                n_state = S_ADDY;
            end
            S_ADDY: begin
                o_cmd.add = 1'b1;
                o_cmd.axis = 1'b1;
                n_state = S_DONE;
            end
            S_SETP: begin
                o_cmd.setpos = 1'b1;
                o_cmd.axis = (r_op == OP_SET_Y);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/ddo_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry datapath
// Pose state, angle term, shift-subtract angle wrap, CORDIC and saturating
// position update.
// ----------------------------------------------------------------------------
module ddo_dp
    import ddo_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic signed [31:0] i_left,
    input  wire logic signed [31:0] i_right,
    input  wire logic signed [31:0] i_set_value,
    input  wire logic        [31:0] i_inv_wheel_base,
    output logic signed [31:0]      o_pose_x,
    output logic signed [31:0]      o_pose_y,
    output logic signed [31:0]      o_heading,
    output logic                    o_saturated
);

    // Pose state.
    logic signed [31:0] r_last_l, r_last_r, r_pos_x, r_pos_y, r_offset, r_heading;
    logic               r_sat;

    // Working registers.
    logic signed [31:0] r_left, r_right, r_val;
    logic signed [61:0] r_term;
    logic signed [38:0] r_dist;
    logic        [62:0] r_mag;
    logic               r_neg;
    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic               r_flip;
    logic signed [31:0] r_c, r_s;
    logic signed [41:0] r_prod;

    // Angle term and distance.
    logic signed [32:0] d_diff;
    logic        [32:0] d_abs;
    logic        [64:0] t_prod;
    logic        [60:0] t_mag;
    logic signed [31:0] dl, dr;
    logic signed [32:0] dsum;
    logic signed [38:0] dsum_x;

    always_comb begin
        d_diff = {r_right[31], r_right} - {r_left[31], r_left};
        d_abs  = d_diff[32] ? 33'(-d_diff) : 33'(d_diff);
        t_prod = 65'(d_abs[31:0] * i_inv_wheel_base)
               + (d_abs[32] ? {1'b0, i_inv_wheel_base, 32'd0} : 65'd0) + 65'd4;
        t_mag  = t_prod[63:3];
        dl     = r_left - r_last_l;
        dr     = r_right - r_last_r;
        dsum   = 33'(dl) + 33'(dr);
        dsum_x = 39'(dsum);
    end

    // Wrap load and one reduction step.
    logic signed [62:0] w_in;
    logic        [63:0] w_sub;
    logic        [64:0] w_diff;
    logic        [32:0] w_r;
    logic signed [33:0] w_res;

    always_comb begin
        unique case (i_cmd.wsel)
            WSEL_SUM:     w_in = 63'(r_offset) + 63'(r_term);
            WSEL_VAL:     w_in = 63'(r_val);
            WSEL_VALTERM: w_in = 63'(r_val) - 63'(r_term);
            default:      w_in = 63'(r_val);
        endcase
        w_sub  = {32'd0, TWO_PI_Q29} << i_cmd.idx;
        w_diff = {2'b00, r_mag} - {1'b0, w_sub};
        // Remainder of the magnitude, folded for negative inputs.
        if (r_neg && r_mag[31:0] != 32'd0) begin
            w_r = {1'b0, TWO_PI_Q29} - {1'b0, r_mag[31:0]};
        end else begin
            w_r = {1'b0, r_mag[31:0]};
        end
        if (w_r > {1'b0, PI_Q29}) begin
            w_res = {1'b0, w_r} - {2'b00, TWO_PI_Q29};
        end else begin
            w_res = {1'b0, w_r};
        end
    end

    // CORDIC.
    logic signed [32:0] c_z0;
    logic               c_flip0;
    logic signed [33:0] c_dx, c_dy;
    logic signed [32:0] c_at;
    logic signed [33:0] c_xf, c_yf, c_xc, c_yc;

    localparam logic signed [33:0] ONE34  = 34'(ONE_Q30);
    localparam logic signed [33:0] NONE34 = -34'(ONE_Q30);

    always_comb begin
        c_z0 = 33'(r_heading);
        c_flip0 = 1'b0;
        if (c_z0 > $signed({1'b0, HALF_PI_Q29})) begin
            c_z0 = c_z0 - 33'(PI_Q29);
            c_flip0 = 1'b1;
        end else if (c_z0 < -$signed({1'b0, HALF_PI_Q29})) begin
            c_z0 = c_z0 + 33'(PI_Q29);
            c_flip0 = 1'b1;
        end
        c_dx = r_y >>> i_cmd.idx;
        c_dy = r_x >>> i_cmd.idx;
        c_at = 33'(atan_q29(i_cmd.idx));
        c_xf = r_flip ? -r_x : r_x;
        c_yf = r_flip ? -r_y : r_y;
        c_xc = (c_xf > ONE34) ? ONE34 : ((c_xf < NONE34) ? NONE34 : c_xf);
        c_yc = (c_yf > ONE34) ? ONE34 : ((c_yf < NONE34) ? NONE34 : c_yf);
    end

    // Scaling of the distance by cosine or sine, rounded from Q1.30.
    logic signed [31:0] m_cv;
    logic        [38:0] m_dabs;
    logic        [30:0] m_cabs;
    logic        [62:0] m_lo;
    logic        [37:0] m_hi;
    logic        [40:0] m_r;
    logic               m_neg;

    always_comb begin
        m_cv   = i_cmd.axis ? r_s : r_c;
        m_neg  = r_dist[38] ^ m_cv[31];
        m_dabs = r_dist[38] ? 39'(-r_dist) : 39'(r_dist);
        m_cabs = m_cv[31] ? 31'(-m_cv) : 31'(m_cv);
        m_lo   = 63'(m_dabs[31:0] * m_cabs);
        m_hi   = 38'(m_dabs[38:32] * m_cabs);
        m_r    = {1'b0, m_hi, 2'b00} + 41'((m_lo + 63'd536870912) >> 30);
    end

    // Saturating add.
    logic signed [42:0] a_sum;
    logic signed [31:0] a_res;
    logic               a_sat;

    always_comb begin
        a_sum = 43'(i_cmd.axis ? r_pos_y : r_pos_x) + 43'(r_prod);
        a_sat = 1'b1;
        if (a_sum > 43'sd2147483647) begin
            a_res = 32'sh7fffffff;
        end else if (a_sum < -43'sd2147483648) begin
            a_res = 32'sh80000000;
        end else begin
            a_res = a_sum[31:0];
            a_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_l  <= '0;
            r_last_r  <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_offset  <= '0;
            r_heading <= '0;
            r_sat     <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_sat <= 1'b0;
            end
            if (i_cmd.wfin) begin
                unique case (i_cmd.wdest)
                    WDST_SAMPLE: begin
                        r_heading <= w_res[31:0];
                        r_last_l  <= r_left;
                        r_last_r  <= r_right;
                    end
                    WDST_HEAD:   r_heading <= w_res[31:0];
                    WDST_OFFSET: r_offset  <= w_res[31:0];
                    default:     r_offset  <= r_offset;
                endcase
            end
            if (i_cmd.setpos) begin
                if (i_cmd.axis) begin
                    r_pos_y <= r_val;
                end else begin
                    r_pos_x <= r_val;
                end
            end
            if (i_cmd.add) begin
                if (i_cmd.axis) begin
                    r_pos_y <= a_res;
                end else begin
                    r_pos_x <= a_res;
                end
                r_sat <= r_sat | a_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_left  <= i_left;
            r_right <= i_right;
            r_val   <= i_set_value;
        end
        if (i_cmd.term) begin
            r_term <= d_diff[32] ? -62'(t_mag) : 62'(t_mag);
            r_dist <= (dsum_x <<< 5) + (dsum_x <<< 4) + (dsum_x <<< 1);
        end
        if (i_cmd.wload) begin
            r_neg <= w_in[62];
            r_mag <= w_in[62] ? 63'(-w_in) : 63'(w_in);
        end
        if (i_cmd.witer && !w_diff[64]) begin
            r_mag <= w_diff[62:0];
        end
        if (i_cmd.cload) begin
            r_x    <= 34'(GAIN_Q30);
            r_y    <= '0;
            r_z    <= c_z0;
            r_flip <= c_flip0;
        end
        if (i_cmd.citer) begin
            if (!r_z[32]) begin
                r_x <= r_x - c_dx;
                r_y <= r_y + c_dy;
                r_z <= r_z - c_at;
            end else begin
                r_x <= r_x + c_dx;
                r_y <= r_y - c_dy;
                r_z <= r_z + c_at;
            end
        end
        if (i_cmd.cfin) begin
            r_c <= c_xc[31:0];
            r_s <= c_yc[31:0];
        end
        if (i_cmd.mul) begin
            r_prod <= m_neg ? -42'(m_r) : 42'(m_r);
        end
    end

    assign o_pose_x    = r_pos_x;
    assign o_pose_y    = r_pos_y;
    assign o_heading   = r_heading;
    assign o_saturated = r_sat;

endmodule
`default_nettype wire

// File: src/diff_drive_odometry.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Differential drive odometry
// Dead-reckoning pose tracker for a two-wheel robot with a CORDIC heading.
// ----------------------------------------------------------------------------
// Channel   Direction  Transaction
// s_axis    in         operation in tuser; left, right, set value in tdata
// m_axis    out        pose x, pose y, heading, saturated flag in tdata
// apb       in         inv_wheel_base register at byte address 0
//
// A sample runs the term step, the shift-subtract angle wrap, the iterative
// CORDIC, the two scale-and-add steps and the result step. A heading set
// runs two wraps, and a position set only the set and result steps. A new
// transaction is taken while the previous result waits in the output
// register; the result stage stalls until m_axis_tready.
// Synchronous reset restores all pose state to zero.
// ----------------------------------------------------------------------------
module diff_drive_odometry
    import ddo_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] left_count, [63:32] right_count, [95:64] set_value
    input  wire logic [95:0]  s_axis_tdata,
    // [1:0] operation
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] pose_x, [63:32] pose_y, [95:64] heading, [96] saturated
    output logic [103:0]      m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0]  r_inv_wheel_base;
    logic         r_out_valid;
    logic [103:0] r_out_data;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic signed [31:0] w_px, w_py, w_hd;
    logic w_sat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INV_WHEEL_BASE) ? r_inv_wheel_base : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_wheel_base <= INV_WHEEL_BASE_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_INV_WHEEL_BASE) begin
            r_inv_wheel_base <= pwdata;
        end
    end

    assign w_sts.in_valid = s_axis_tvalid;
    assign w_sts.in_op    = s_axis_tuser;
    assign w_sts.out_free = !r_out_valid || m_axis_tready;

    ddo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    ddo_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_left           (s_axis_tdata[31:0]),
        .i_right          (s_axis_tdata[63:32]),
        .i_set_value      (s_axis_tdata[95:64]),
        .i_inv_wheel_base (r_inv_wheel_base),
        .o_pose_x         (w_px),
        .o_pose_y         (w_py),
        .o_heading        (w_hd),
        .o_saturated      (w_sat)
    );

    assign s_axis_tready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_data <= {7'd0, w_sat, w_hd, w_py, w_px};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire
